// File: rtl/core/dstg_pkg.sv
// ----------------------------------------------------------------------------
// dstg_pkg
// Shared constants, types and the sine table builder for the decaying sine
// tone generator.
// ----------------------------------------------------------------------------
package dstg_pkg;

    localparam int SINE_TABLE_BITS = 10;
    localparam int SAMPLE_WIDTH    = 24;

    localparam int PHASE_WIDTH     = 32;
    localparam int ENV_WIDTH       = 32;
    localparam int AMP_WIDTH       = 16;
    localparam int DATA_WIDTH      = 32;
    localparam int PROD_WIDTH      = 2 * ENV_WIDTH;
    localparam int SINE_WIDTH      = 31;
    localparam int QSIZE           = 1 << SINE_TABLE_BITS;
    localparam int SINE_ADDR_WIDTH = SINE_TABLE_BITS + 1;

    // APB register map: register i at byte address 4*i
    localparam int   ADDR_WIDTH  = 3;
    localparam int   REG_SEL_BIT = 2;
    localparam logic REG_DECAY   = 1'b0;

    localparam logic [ENV_WIDTH-1:0]  ENV_ONE     = 32'h8000_0000;
    localparam logic [DATA_WIDTH-1:0] DECAY_RESET = 32'd2147457878;
    localparam logic [63:0]           HALF_PI_Q30 = 64'd1686629713;

    // Q.61 product to Q1.(SAMPLE_WIDTH-1), round half up
    localparam int                    RND_SHIFT = 62 - SAMPLE_WIDTH;
    localparam logic [PROD_WIDTH-1:0] RND_BIAS  = 64'd1 << (61 - SAMPLE_WIDTH);
    localparam int                    MAG_WIDTH = PROD_WIDTH - RND_SHIFT;

    localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SINE,
        ST_DECAY,
        ST_UPDATE
    } dstg_state_t;

    typedef struct packed {
        logic accept;
        logic sine_step;
        logic decay_step;
        logic update;
    } dstg_ctrl_t;

    // next Taylor term magnitude before the factorial step
    function automatic logic [63:0] taylor_raise(input logic [63:0] term,
                                                 input logic [63:0] x);
        logic [63:0] t;
        t = (term * x) >> 30;
        t = (t * x) >> 30;
        return t;
    endfunction

    // quarter-wave entry k: sin(k*pi/(2*QSIZE)) in unsigned Q1.30
    function automatic logic [SINE_WIDTH-1:0] sine_entry(
        input logic [SINE_ADDR_WIDTH-1:0] k);
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x    = ({{(64-SINE_ADDR_WIDTH){1'b0}}, k} * HALF_PI_Q30) >> SINE_TABLE_BITS;
        term = x;
        sum  = signed'(x);
        term = taylor_raise(term, x) / 64'd6;
        sum  = sum - signed'(term);
        term = taylor_raise(term, x) / 64'd20;
        sum  = sum + signed'(term);
        term = taylor_raise(term, x) / 64'd42;
        sum  = sum - signed'(term);
        term = taylor_raise(term, x) / 64'd72;
        sum  = sum + signed'(term);
        term = taylor_raise(term, x) / 64'd110;
        sum  = sum - signed'(term);
        term = taylor_raise(term, x) / 64'd156;
        sum  = sum + signed'(term);
        term = taylor_raise(term, x) / 64'd210;
        sum  = sum - signed'(term);
        term = taylor_raise(term, x) / 64'd272;
        sum  = sum + signed'(term);
        if (sum < 64'sd0)
        begin
            sum = 64'sd0;
        end
        if (sum > 64'sd1073741824)
        begin
            sum = 64'sd1073741824;
        end
        return sum[SINE_WIDTH-1:0];
    endfunction

endpackage

// File: rtl/core/dstg_if.sv
// ----------------------------------------------------------------------------
// dstg_if
// Valid/ready channels for the tone generator: request word in, sample out.
// ----------------------------------------------------------------------------
interface dstg_in_if;
    logic                               valid;
    logic                               ready;
    logic                               restart;
    logic [dstg_pkg::PHASE_WIDTH-1:0]   phase_step;
    logic [dstg_pkg::AMP_WIDTH-1:0]     amplitude;

    modport source (output valid, restart, phase_step, amplitude, input ready);
    modport sink   (input valid, restart, phase_step, amplitude, output ready);
endinterface

interface dstg_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [dstg_pkg::SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, sample, input ready);
    modport sink   (input valid, sample, output ready);
endinterface

// File: rtl/core/dstg_sine_rom.sv
// ----------------------------------------------------------------------------
// dstg_sine_rom
// Quarter-wave sine ROM, QSIZE+1 entries, registered read.
// ----------------------------------------------------------------------------
module dstg_sine_rom (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [dstg_pkg::SINE_ADDR_WIDTH-1:0] addr,
    output logic [dstg_pkg::SINE_WIDTH-1:0]      data
);

    logic [dstg_pkg::SINE_WIDTH-1:0] sine_lut [0:dstg_pkg::QSIZE];
    logic [dstg_pkg::SINE_WIDTH-1:0] data_reg;

    for (genvar k = 0; k <= dstg_pkg::QSIZE; k++)
    begin : g_lut
        localparam logic [dstg_pkg::SINE_WIDTH-1:0] ENTRY =
            dstg_pkg::sine_entry(dstg_pkg::SINE_ADDR_WIDTH'(k));
        assign sine_lut[k] = ENTRY;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= sine_lut[addr];
        end
    end

    assign data = data_reg;

endmodule

// File: rtl/core/dstg_ctrl.sv
// ----------------------------------------------------------------------------
// dstg_ctrl
// Sequencer: steps the shared multiplier through gain, sine and decay, and
// owns the output word handshake.
// ----------------------------------------------------------------------------
module dstg_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  out_ready,
    output logic                  in_ready,
    output logic                  out_valid,
    output dstg_pkg::dstg_ctrl_t  ctrl
);

    dstg_pkg::dstg_state_t state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dstg_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = dstg_pkg::ST_SINE;
                end
            end
            dstg_pkg::ST_SINE:
            begin
                state_next = dstg_pkg::ST_DECAY;
            end
            dstg_pkg::ST_DECAY:
            begin
                state_next = dstg_pkg::ST_UPDATE;
            end
            dstg_pkg::ST_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = dstg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dstg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl     = '0;
        in_ready = 1'b0;
        case (state_reg)
            dstg_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                ctrl.accept = in_valid;
            end
            dstg_pkg::ST_SINE:
            begin
                ctrl.sine_step = 1'b1;
            end
            dstg_pkg::ST_DECAY:
            begin
                ctrl.decay_step = 1'b1;
            end
            dstg_pkg::ST_UPDATE:
            begin
                ctrl.update = out_free;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.update)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dstg_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/core/dstg_datapath.sv
// ----------------------------------------------------------------------------
// dstg_datapath
// Phase and envelope state, sine lookup, one shared 32x32 multiplier, and
// rounding/saturation of the sample.
// ----------------------------------------------------------------------------
module dstg_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dstg_pkg::dstg_ctrl_t                ctrl,
    input  logic                                restart,
    input  logic [dstg_pkg::PHASE_WIDTH-1:0]    phase_step,
    input  logic [dstg_pkg::AMP_WIDTH-1:0]      amplitude,
    input  logic [dstg_pkg::DATA_WIDTH-1:0]     decay,
    output logic [dstg_pkg::SAMPLE_WIDTH-1:0]   sample
);

    localparam int PW  = dstg_pkg::PHASE_WIDTH;
    localparam int EW  = dstg_pkg::ENV_WIDTH;
    localparam int SW  = dstg_pkg::SAMPLE_WIDTH;
    localparam int TB  = dstg_pkg::SINE_TABLE_BITS;
    localparam int AW  = dstg_pkg::SINE_ADDR_WIDTH;
    localparam int MW  = dstg_pkg::MAG_WIDTH;
    localparam int XW  = dstg_pkg::PROD_WIDTH;

    logic [PW-1:0]  phase_reg, phase_next;
    logic [EW-1:0]  env_reg, env_next;
    logic [PW-1:0]  step_reg, step_next;
    logic [1:0]     quad_reg, quad_next;
    logic [XW-1:0]  prod_reg, prod_next;
    logic [SW-1:0]  res_reg, res_next;
    logic [SW-1:0]  sample_reg, sample_next;

    logic [PW-1:0]  phase_cur;
    logic [EW-1:0]  env_cur;
    logic [TB-1:0]  idx;
    logic [AW-1:0]  rom_addr;
    logic [dstg_pkg::SINE_WIDTH-1:0] rom_data;
    logic [EW-1:0]  mul_a, mul_b;
    logic [XW-1:0]  mul_p;
    logic [XW-1:0]  rounded;
    logic [MW-1:0]  mag;
    logic [SW-1:0]  mag_sat;
    logic [EW:0]    env_scaled;
    logic [EW-1:0]  env_upd;

    assign phase_cur = restart ? '0 : phase_reg;
    assign env_cur   = restart ? dstg_pkg::ENV_ONE : env_reg;
    assign idx       = phase_cur[PW-3 -: TB];
    assign rom_addr  = phase_cur[PW-2] ? (AW'(dstg_pkg::QSIZE) - {1'b0, idx}) : {1'b0, idx};

    dstg_sine_rom u_rom (
        .clk  (clk),
        .en   (ctrl.accept),
        .addr (rom_addr),
        .data (rom_data)
    );

    // shared multiplier: gain, then gain*sine, then envelope*decay
    always_comb
    begin
        if (ctrl.accept)
        begin
            mul_a = env_cur;
            mul_b = {{(EW-dstg_pkg::AMP_WIDTH){1'b0}}, amplitude};
        end
        else if (ctrl.sine_step)
        begin
            mul_a = prod_reg[EW+14:15];
            mul_b = {{(EW-dstg_pkg::SINE_WIDTH){1'b0}}, rom_data};
        end
        else
        begin
            mul_a = env_reg;
            mul_b = decay;
        end
    end

    assign mul_p = {{EW{1'b0}}, mul_a} * {{EW{1'b0}}, mul_b};

    assign rounded = prod_reg + dstg_pkg::RND_BIAS;
    assign mag     = rounded[XW-1:dstg_pkg::RND_SHIFT];
    assign mag_sat = (mag > MW'(dstg_pkg::SAMPLE_MAX)) ? dstg_pkg::SAMPLE_MAX : mag[SW-1:0];

    assign env_scaled = prod_reg[XW-1:EW-1];
    assign env_upd    = (env_scaled > {1'b0, dstg_pkg::ENV_ONE}) ? dstg_pkg::ENV_ONE
                                                                  : env_scaled[EW-1:0];

    always_comb
    begin
        phase_next  = phase_reg;
        env_next    = env_reg;
        step_next   = step_reg;
        quad_next   = quad_reg;
        prod_next   = prod_reg;
        res_next    = res_reg;
        sample_next = sample_reg;
        if (ctrl.accept)
        begin
            phase_next = phase_cur;
            env_next   = env_cur;
            step_next  = phase_step;
            quad_next  = phase_cur[PW-1:PW-2];
        end
        if (ctrl.accept || ctrl.sine_step || ctrl.decay_step)
        begin
            prod_next = mul_p;
        end
        if (ctrl.decay_step)
        begin
            res_next = quad_reg[1] ? (SW'(0) - mag_sat) : mag_sat;
        end
        if (ctrl.update)
        begin
            env_next    = env_upd;
            phase_next  = phase_reg + step_reg;
            sample_next = res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            env_reg   <= dstg_pkg::ENV_ONE;
        end
        else
        begin
            phase_reg <= phase_next;
            env_reg   <= env_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg   <= step_next;
        quad_reg   <= quad_next;
        prod_reg   <= prod_next;
        res_reg    <= res_next;
        sample_reg <= sample_next;
    end

    assign sample = sample_reg;

endmodule

// File: rtl/core/decaying_sine_tone_generator.sv
// A request is taken in idle; sine, decay and update steps follow and the sample
// word is registered after update. Ready stays low from each accept until idle
// while the single 32x32 multiplier runs gain, sine scaling and envelope decay.
// A stalled output holds the sequencer in its last step until the word leaves.
// Reset: phase 0, envelope 1.0, decay factor 0.999988; no clearing pass.
// ----------------------------------------------------------------------------
// decaying_sine_tone_generator
// NCO sine oscillator with exponential decay envelope and APB decay register.
// ----------------------------------------------------------------------------
module decaying_sine_tone_generator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dstg_pkg::ADDR_WIDTH-1:0]     paddr,
    input  logic [dstg_pkg::DATA_WIDTH-1:0]     pwdata,
    output logic [dstg_pkg::DATA_WIDTH-1:0]     prdata,
    output logic                                pready,
    dstg_in_if.sink                             in_ch,
    dstg_out_if.source                          out_ch
);

    logic [dstg_pkg::DATA_WIDTH-1:0] decay_reg, decay_next;
    logic                            decay_wr;
    dstg_pkg::dstg_ctrl_t            ctrl;
    logic [dstg_pkg::SAMPLE_WIDTH-1:0] sample;

    assign pready   = 1'b1;
    assign decay_wr = psel && penable && pwrite
                      && (paddr[dstg_pkg::REG_SEL_BIT] == dstg_pkg::REG_DECAY);
    assign prdata   = (paddr[dstg_pkg::REG_SEL_BIT] == dstg_pkg::REG_DECAY) ? decay_reg : '0;

    always_comb
    begin
        decay_next = decay_reg;
        if (decay_wr)
        begin
            decay_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg <= dstg_pkg::DECAY_RESET;
        end
        else
        begin
            decay_reg <= decay_next;
        end
    end

    dstg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .out_ready (out_ch.ready),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .ctrl      (ctrl)
    );

    dstg_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .restart    (in_ch.restart),
        .phase_step (in_ch.phase_step),
        .amplitude  (in_ch.amplitude),
        .decay      (decay_reg),
        .sample     (sample)
    );

    assign out_ch.sample = sample;

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("input taken while an item is in progress");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && !out_ch.valid) |-> ##4 out_ch.valid)
        else $error("sample word not offered four cycles after accept");

    a_no_min_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.sample != dstg_pkg::SAMPLE_MIN))
        else $error("sample saturation produced the most negative code");
`endif

endmodule
